// File: rtl/mcr_pkg.sv
// mcr_pkg: shared types, opcodes, field widths and the binomial rom for the
// masked combination ranker; no dependencies
`default_nettype none

package mcr_pkg;

	localparam int unsigned OPCODE_W  = 2;
	localparam int unsigned MASK_W    = 16;
	localparam int unsigned MEMBER_W  = 4;
	localparam int unsigned IDX_IN_W  = 12;
	localparam int unsigned IDX_OUT_W = 11;
	localparam int unsigned SET_OUT_W = 13;
	localparam int unsigned COUNT_W   = 11;
	localparam int unsigned BINOM_W   = 14;
	localparam int unsigned ACC_W     = 16;

	localparam logic [OPCODE_W-1:0] OP_RANK   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_UNRANK = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_COUNT  = 2'd2;

	typedef struct packed {
		logic capture;
		logic check;
		logic step;
		logic load_out;
	} mcr_cmd_t;

	typedef struct packed {
		logic needs_run;
		logic last;
	} mcr_status_t;

	// rows n = 0..16, columns k = 0..8 (upper half by symmetry)
	typedef logic [16:0][8:0][BINOM_W-1:0] binom_rom_t;

	function automatic binom_rom_t build_binom();
		logic [16:0][16:0][15:0] t;
		binom_rom_t r;
		t = '0;
		r = '0;
		for (int n = 0; n <= 16; n++) begin
			t[n][0] = 16'd1;
			for (int k = 1; k <= n; k++) begin
				t[n][k] = t[n-1][k-1] + t[n-1][k];
			end
		end
		for (int n = 0; n <= 16; n++) begin
			for (int k = 0; k <= 8; k++) begin
				r[n][k] = t[n][k][BINOM_W-1:0];
			end
		end
		return r;
	endfunction

	localparam binom_rom_t BINOM_ROM = build_binom();

	function automatic logic [BINOM_W-1:0] binom_lookup(input logic [4:0] n, input logic [4:0] k);
		logic [4:0] kk;
		logic [BINOM_W-1:0] r;
		kk = '0;
		r  = '0;
		if (k <= n && n <= 5'd16) begin
			kk = ((n - k) < k) ? (n - k) : k;
			r  = BINOM_ROM[n][kk[3:0]];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mcr_ctrl.sv
// mcr_ctrl: sequencing state machine for the masked combination ranker
// depends on mcr_pkg (command and status structs)
`default_nettype none

module mcr_ctrl
	import mcr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire mcr_status_t status,
	output mcr_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RUN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.capture  = in_valid && (state_q == ST_IDLE);
		cmd.check    = (state_q == ST_CHECK);
		cmd.step     = (state_q == ST_RUN);
		cmd.load_out = (state_q == ST_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= status.needs_run ? ST_RUN : ST_FINISH;
				end
				ST_RUN: begin
					if (status.last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_capture_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_CHECK))
		else $error("capture did not start a check");

	a_skip_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.check && !status.needs_run) |=> (state_q == ST_FINISH))
		else $error("check without run did not finish");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && status.last) |=> (state_q == ST_FINISH))
		else $error("last step did not finish");

	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

endmodule

`default_nettype wire

// File: rtl/mcr_datapath.sv
// mcr_datapath: operand registers, validity checks, shared binomial lookup,
// rank and unrank scan registers and result registers; depends on mcr_pkg
`default_nettype none

module mcr_datapath
	import mcr_pkg::*;
#(
	parameter int unsigned NUM_RANKS = 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mcr_cmd_t             cmd,
	output mcr_status_t               status,
	input  wire logic [OPCODE_W-1:0]  opcode,
	input  wire logic [MASK_W-1:0]    set_bits,
	input  wire logic [MASK_W-1:0]    used_bits,
	input  wire logic [MEMBER_W-1:0]  member_count,
	input  wire logic [IDX_IN_W-1:0]  index_in,
	output logic [IDX_OUT_W-1:0]      index_out,
	output logic [SET_OUT_W-1:0]      set_out,
	output logic [COUNT_W-1:0]        count_out,
	output logic                      invalid
);

	localparam int unsigned PW = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
	localparam int unsigned CW = $clog2(NUM_RANKS + 1);
	localparam logic [PW-1:0] P_LAST = PW'(NUM_RANKS - 1);
	localparam logic [MASK_W-1:0] FIELD_MASK = MASK_W'((32'd1 << NUM_RANKS) - 32'd1);

	logic [OPCODE_W-1:0]  op_q;
	logic [MASK_W-1:0]    set_q;
	logic [MASK_W-1:0]    used_q;
	logic [MEMBER_W-1:0]  m_q;
	logic [IDX_IN_W-1:0]  idx_q;

	logic                 bad_q;
	logic [BINOM_W-1:0]   count_q;
	logic [PW-1:0]        p_q;
	logic [CW-1:0]        ub_q;
	logic [CW-1:0]        i_q;
	logic [ACC_W-1:0]     acc_q;
	logic [CW-1:0]        fcnt_q;
	logic [MEMBER_W-1:0]  k_q;
	logic [IDX_IN_W-1:0]  rem_q;
	logic [NUM_RANKS-1:0] res_q;

	logic [IDX_OUT_W-1:0] index_out_q;
	logic [SET_OUT_W-1:0] set_out_q;
	logic [COUNT_W-1:0]   count_out_q;
	logic                 invalid_q;

	logic [NUM_RANKS-1:0] set_r;
	logic [NUM_RANKS-1:0] used_r;
	logic [4:0]           used_n;
	logic [5:0]           free_n;
	logic                 used_ok;
	logic                 set_ok;
	logic                 fit_ok;
	logic                 idx_ok;
	logic                 bad_now;
	logic [4:0]           lu_n;
	logic [4:0]           lu_k;
	logic [BINOM_W-1:0]   bval;
	logic                 take;

	assign set_r  = set_q[NUM_RANKS-1:0];
	assign used_r = used_q[NUM_RANKS-1:0];

	always_comb begin
		used_n  = 5'($countones(used_q));
		free_n  = 6'(NUM_RANKS) - 6'(used_n);
		used_ok = (used_q & ~FIELD_MASK) == '0;
		set_ok  = ((set_q & ~FIELD_MASK) == '0) && ((set_q & used_q) == '0);
		fit_ok  = (6'(used_n) + 6'(m_q)) <= 6'(NUM_RANKS);

		if (cmd.check) begin
			lu_n = 5'(free_n);
			lu_k = 5'(m_q);
		end else if (op_q == OP_RANK) begin
			lu_n = 5'(p_q) - 5'(ub_q);
			lu_k = 5'(i_q) + 5'd1;
		end else begin
			lu_n = 5'(fcnt_q) - 5'd1;
			lu_k = 5'(k_q);
		end
		bval = binom_lookup(lu_n, lu_k);

		idx_ok = BINOM_W'(idx_q) < bval;
		case (op_q)
			OP_RANK:   bad_now = !(used_ok && set_ok);
			OP_UNRANK: bad_now = !(used_ok && fit_ok && idx_ok);
			OP_COUNT:  bad_now = !(used_ok && fit_ok);
			default:   bad_now = 1'b1;
		endcase

		take = (k_q != '0) && (BINOM_W'(rem_q) >= bval);

		status.needs_run = !bad_now && ((op_q == OP_RANK) || (op_q == OP_UNRANK));
		status.last      = ((op_q == OP_RANK) && (p_q == P_LAST)) ||
		                   ((op_q == OP_UNRANK) && (p_q == '0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q        <= '0;
			set_q       <= '0;
			used_q      <= '0;
			m_q         <= '0;
			idx_q       <= '0;
			bad_q       <= 1'b0;
			count_q     <= '0;
			p_q         <= '0;
			ub_q        <= '0;
			i_q         <= '0;
			acc_q       <= '0;
			fcnt_q      <= '0;
			k_q         <= '0;
			rem_q       <= '0;
			res_q       <= '0;
			invalid_q   <= 1'b0;
			index_out_q <= '0;
			set_out_q   <= '0;
			count_out_q <= '0;
		end else begin
			if (cmd.capture) begin
				op_q   <= opcode;
				set_q  <= set_bits;
				used_q <= used_bits;
				m_q    <= member_count;
				idx_q  <= index_in;
			end

			if (cmd.check) begin
				bad_q   <= bad_now;
				count_q <= bval;
				p_q     <= (op_q == OP_RANK) ? '0 : P_LAST;
				ub_q    <= '0;
				i_q     <= '0;
				acc_q   <= '0;
				fcnt_q  <= CW'(free_n);
				k_q     <= m_q;
				rem_q   <= idx_q;
				res_q   <= '0;
			end else if (cmd.step) begin
				if (op_q == OP_RANK) begin
					p_q <= p_q + PW'(1);
					if (used_r[p_q]) begin
						ub_q <= ub_q + CW'(1);
					end
					if (set_r[p_q]) begin
						acc_q <= acc_q + ACC_W'(bval);
						i_q   <= i_q + CW'(1);
					end
				end else begin
					p_q <= p_q - PW'(1);
					if (!used_r[p_q]) begin
						fcnt_q <= fcnt_q - CW'(1);
						if (take) begin
							res_q[p_q] <= 1'b1;
							rem_q      <= rem_q - IDX_IN_W'(bval);
							k_q        <= k_q - MEMBER_W'(1);
						end
					end
				end
			end

			if (cmd.load_out) begin
				invalid_q   <= bad_q;
				index_out_q <= (!bad_q && (op_q == OP_RANK)) ? acc_q[IDX_OUT_W-1:0] : '0;
				set_out_q   <= (!bad_q && (op_q == OP_UNRANK)) ? SET_OUT_W'(res_q) : '0;
				count_out_q <= (!bad_q && (op_q == OP_COUNT)) ? count_q[COUNT_W-1:0] : '0;
			end
		end
	end

	assign index_out = index_out_q;
	assign set_out   = set_out_q;
	assign count_out = count_out_q;
	assign invalid   = invalid_q;

endmodule

`default_nettype wire

// File: rtl/masked_combination_ranker.sv
// masked_combination_ranker: top level, colex rank / unrank / count over a
// masked universe; depends on mcr_pkg, mcr_ctrl, mcr_datapath
//
// channel  handshake            payload
// in       in_valid / in_ready  opcode, set_bits, used_bits, member_count, index_in
// out      out_valid / out_ready index_out, set_out, count_out, invalid
//
// rank and unrank step through the check, run and finish states, with
// one scan step per position, each with one binomial rom lookup
// count and rejected operands go from the check state straight to finish
// one beat is in work at a time; the next is taken while a result waits
// a stalled output holds the finished beat and the scan until out_ready
// no clearing pass after reset
`default_nettype none

module masked_combination_ranker
	import mcr_pkg::*;
#(
	parameter int unsigned NUM_RANKS = 13
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [OPCODE_W-1:0]  opcode,
	input  wire logic [MASK_W-1:0]    set_bits,
	input  wire logic [MASK_W-1:0]    used_bits,
	input  wire logic [MEMBER_W-1:0]  member_count,
	input  wire logic [IDX_IN_W-1:0]  index_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [IDX_OUT_W-1:0]      index_out,
	output logic [SET_OUT_W-1:0]      set_out,
	output logic [COUNT_W-1:0]        count_out,
	output logic                      invalid
);

	mcr_cmd_t    cmd;
	mcr_status_t status;

	mcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mcr_datapath #(
		.NUM_RANKS (NUM_RANKS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.opcode       (opcode),
		.set_bits     (set_bits),
		.used_bits    (used_bits),
		.member_count (member_count),
		.index_in     (index_in),
		.index_out    (index_out),
		.set_out      (set_out),
		.count_out    (count_out),
		.invalid      (invalid)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb_masked_combination_ranker.sv
// tb_masked_combination_ranker: self-checking bench for the colex rank / unrank / count block
// random burst driver, stalling sink, in-bench result prediction and scoreboard
// depends on mcr_pkg and masked_combination_ranker
`default_nettype none

module tb_masked_combination_ranker;
	import mcr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANKS = 13;
	localparam int unsigned POS_SPAN = 16;
	localparam logic [MASK_W-1:0] POS_MASK = MASK_W'((1 << RANKS) - 1);
	localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
	localparam int unsigned RANDOM_BEATS = 1625;
	localparam int unsigned DRAIN_EVERY = 400;
	localparam int unsigned TAIL_CYCLES = 64;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned PRINT_CAP = 50;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [MASK_W-1:0]   set_bits;
		logic [MASK_W-1:0]   used_bits;
		logic [MEMBER_W-1:0] member_count;
		logic [IDX_IN_W-1:0] index_in;
		logic                drain;
	} operand_t;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] index_out;
		logic [SET_OUT_W-1:0] set_out;
		logic [COUNT_W-1:0]   count_out;
		logic                 invalid;
	} ranker_result_t;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OPCODE_W-1:0] opcode = '0;
	logic [MASK_W-1:0] set_bits = '0;
	logic [MASK_W-1:0] used_bits = '0;
	logic [MEMBER_W-1:0] member_count = '0;
	logic [IDX_IN_W-1:0] index_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_OUT_W-1:0] index_out;
	logic [SET_OUT_W-1:0] set_out;
	logic [COUNT_W-1:0] count_out;
	logic invalid;

	operand_t pending_operands[$];
	ranker_result_t expected_results[$];
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	logic in_beat = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	logic [15:0] stall_pattern = 16'hFFFF;
	int unsigned stall_span = 0;

	masked_combination_ranker #(
		.NUM_RANKS(RANKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.set_bits(set_bits),
		.used_bits(used_bits),
		.member_count(member_count),
		.index_in(index_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.index_out(index_out),
		.set_out(set_out),
		.count_out(count_out),
		.invalid(invalid)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned choose(input int unsigned n, input int unsigned k);
		int unsigned r;
		int unsigned kk;
		int unsigned i;
		r = 1;
		kk = k;
		if (kk > n || n > POS_SPAN)
			return 0;
		if (n - kk < kk)
			kk = n - kk;
		for (i = 0; i < kk; i++)
			r = r * (n - i) / (i + 1);
		return r;
	endfunction

	function automatic int unsigned free_slot(input logic [MASK_W-1:0] used,
			input int unsigned order);
		int unsigned seen;
		int unsigned p;
		seen = 0;
		for (p = 0; p < POS_SPAN; p++) begin
			if (!used[p]) begin
				if (seen == order)
					return p;
				seen++;
			end
		end
		return POS_SPAN;
	endfunction

	function automatic ranker_result_t colex_result(input operand_t op);
		ranker_result_t res;
		logic used_ok;
		logic bad;
		int unsigned used_n;
		int unsigned m;
		int unsigned acc;
		int unsigned members;
		int unsigned c;
		int unsigned p;
		int unsigned i;
		int unsigned k;
		int unsigned cnt;
		int unsigned rem;
		int unsigned pos;
		logic [MASK_W-1:0] below;
		logic [POS_SPAN-1:0] picked;
		res = '0;
		bad = 1'b1;
		used_ok = (op.used_bits & ~POS_MASK) == '0;
		used_n = $countones(op.used_bits);
		m = 32'(op.member_count);
		case (op.opcode)
			OP_RANK: begin
				if (used_ok && (op.set_bits & ~POS_MASK) == '0
						&& (op.set_bits & op.used_bits) == '0) begin
					acc = 0;
					members = 0;
					for (p = 0; p < POS_SPAN; p++) begin
						if (op.set_bits[p]) begin
							below = op.used_bits & MASK_W'((1 << p) - 1);
							c = p - $countones(below);
							if (c >= members + 1)
								acc += choose(c, members + 1);
							members++;
						end
					end
					res.index_out = IDX_OUT_W'(acc);
					bad = 1'b0;
				end
			end
			OP_UNRANK: begin
				if (used_ok && used_n + m <= RANKS
						&& 32'(op.index_in) < choose(RANKS - used_n, m)) begin
					rem = 32'(op.index_in);
					picked = '0;
					for (i = 0; i < m; i++) begin
						k = m - i;
						cnt = 0;
						while (cnt < POS_SPAN && choose(cnt + 1, k) <= rem)
							cnt++;
						if (cnt >= k)
							rem -= choose(cnt, k);
						pos = free_slot(op.used_bits, cnt);
						if (pos < POS_SPAN)
							picked[pos] = 1'b1;
					end
					res.set_out = picked[SET_OUT_W-1:0];
					bad = 1'b0;
				end
			end
			OP_COUNT: begin
				if (used_ok && used_n + m <= RANKS) begin
					res.count_out = COUNT_W'(choose(RANKS - used_n, m));
					bad = 1'b0;
				end
			end
			default: begin
			end
		endcase
		if (bad)
			res = '0;
		res.invalid = bad;
		return res;
	endfunction

	task automatic queue_operand(input logic [OPCODE_W-1:0] op, input logic [MASK_W-1:0] set_v,
			input logic [MASK_W-1:0] used_v, input logic [MEMBER_W-1:0] m,
			input logic [IDX_IN_W-1:0] idx, input logic drain);
		operand_t item;
		item.opcode = op;
		item.set_bits = set_v;
		item.used_bits = used_v;
		item.member_count = m;
		item.index_in = idx;
		item.drain = drain;
		pending_operands.push_back(item);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what,
				got, want);
	endtask

	task automatic queue_directed();
		queue_operand(OP_RANK, 16'h0000, 16'h0000, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_RANK, 16'h1FFF, 16'h0000, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_RANK, 16'h0001, 16'h0000, 4'd5, 12'd77, 1'b0);
		queue_operand(OP_RANK, 16'h1000, 16'h0FFF, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_RANK, 16'h0AAA, 16'h1555, 4'd15, 12'hFFF, 1'b0);
		queue_operand(OP_RANK, 16'h0003, 16'h0002, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_RANK, 16'h2000, 16'h0000, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_RANK, 16'h0001, 16'h8000, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_UNRANK, 16'hFFFF, 16'h0000, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h0000, 4'd13, 12'd0, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h0000, 4'd6, 12'd1715, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h0000, 4'd6, 12'd1716, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h0000, 4'd13, 12'hFFF, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h0010, 4'd13, 12'd0, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h1FFF, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h00F0, 4'd4, 12'd125, 1'b0);
		queue_operand(OP_UNRANK, 16'h0000, 16'h4000, 4'd1, 12'd0, 1'b0);
		queue_operand(OP_COUNT, 16'h0000, 16'h0000, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_COUNT, 16'h0000, 16'h0000, 4'd6, 12'd0, 1'b0);
		queue_operand(OP_COUNT, 16'h0000, 16'h0000, 4'd13, 12'd0, 1'b0);
		queue_operand(OP_COUNT, 16'h0000, 16'h1FFF, 4'd1, 12'd0, 1'b0);
		queue_operand(OP_COUNT, 16'h0000, 16'h0000, 4'd15, 12'd0, 1'b0);
		queue_operand(OP_SPARE, 16'hFFFF, 16'hFFFF, 4'd15, 12'hFFF, 1'b0);
		queue_operand(OP_SPARE, 16'h0000, 16'h0000, 4'd0, 12'd0, 1'b0);
		queue_operand(OP_COUNT, 16'h0000, 16'hFFFF, 4'd0, 12'd0, 1'b0);
	endtask

	task automatic queue_random();
		int unsigned n;
		int unsigned pick;
		int unsigned free_n;
		int unsigned total;
		int unsigned m;
		logic [MASK_W-1:0] used_v;
		logic [MASK_W-1:0] set_v;
		logic [IDX_IN_W-1:0] idx;
		logic drain;
		for (n = 0; n < RANDOM_BEATS; n++) begin
			drain = (n % DRAIN_EVERY) == 0;
			case ($urandom_range(0, 3))
				0: used_v = '0;
				1: used_v = MASK_W'($urandom) & MASK_W'($urandom) & POS_MASK;
				2: used_v = MASK_W'($urandom) & MASK_W'($urandom) & MASK_W'($urandom) & POS_MASK;
				default: used_v = MASK_W'($urandom) & POS_MASK;
			endcase
			free_n = RANKS - $countones(used_v);
			set_v = MASK_W'($urandom);
			idx = IDX_IN_W'($urandom);
			m = $urandom_range(0, 15);
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				set_v = MASK_W'($urandom) & POS_MASK & ~used_v;
				queue_operand(OP_RANK, set_v, used_v, MEMBER_W'(m), idx, drain);
			end else if (pick < 55) begin
				m = $urandom_range(0, free_n);
				total = choose(free_n, m);
				idx = IDX_IN_W'($urandom_range(0, total - 1));
				queue_operand(OP_UNRANK, set_v, used_v, MEMBER_W'(m), idx, drain);
			end else if (pick < 72) begin
				m = $urandom_range(0, free_n);
				queue_operand(OP_COUNT, set_v, used_v, MEMBER_W'(m), idx, drain);
			end else if (pick < 86) begin
				case ($urandom_range(0, 4))
					0: begin
						m = $urandom_range(0, free_n);
						idx = IDX_IN_W'(choose(free_n, m) + $urandom_range(0, 3));
						queue_operand(OP_UNRANK, set_v, used_v, MEMBER_W'(m), idx, drain);
					end
					1: begin
						m = $urandom_range(free_n, 15);
						queue_operand(OP_UNRANK, set_v, used_v, MEMBER_W'(m), idx, drain);
					end
					2: begin
						set_v = (MASK_W'($urandom) & POS_MASK)
							| (used_v & ~(used_v - 16'd1)) | 16'h0001;
						queue_operand(OP_RANK, set_v, used_v, MEMBER_W'(m), idx, drain);
					end
					3: begin
						set_v = (MASK_W'($urandom) & POS_MASK & ~used_v)
							| MASK_W'(1 << $urandom_range(RANKS, MASK_W - 1));
						queue_operand(OP_RANK, set_v, used_v, MEMBER_W'(m), idx, drain);
					end
					default: begin
						used_v = used_v | MASK_W'(1 << $urandom_range(RANKS, MASK_W - 1));
						queue_operand(OPCODE_W'($urandom_range(0, 2)),
							set_v & POS_MASK & ~used_v, used_v,
							MEMBER_W'($urandom_range(0, 3)), '0, drain);
					end
				endcase
			end else begin
				queue_operand(OPCODE_W'($urandom_range(0, 3)), MASK_W'($urandom),
					MASK_W'($urandom), MEMBER_W'($urandom), IDX_IN_W'($urandom), drain);
			end
		end
	endtask

	// sender: bursts of beats separated by random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_beat) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_operands.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_operands[0].drain && expected_results.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					opcode <= pending_operands[0].opcode;
					set_bits <= pending_operands[0].set_bits;
					used_bits <= pending_operands[0].used_bits;
					member_count <= pending_operands[0].member_count;
					index_in <= pending_operands[0].index_in;
					void'(pending_operands.pop_front());
					in_valid <= 1'b1;
					if (burst_left != 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end
				end
			end
		end
	end

	// receiver: ready follows a rotating pattern that changes now and then
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_span == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pattern = 16'hFFFF;
					1: stall_pattern = 16'($urandom) | 16'h0001;
					2: stall_pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
					default: stall_pattern = (16'($urandom) & 16'($urandom)) | 16'h0001;
				endcase
				stall_span = $urandom_range(50, 300);
			end else begin
				stall_span--;
			end
			out_ready <= stall_pattern[0];
			stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	always @(posedge clk) begin
		ranker_result_t want;
		operand_t seen;
		if (arst_n) begin
			in_beat = in_valid && in_ready;
			if (in_beat) begin
				seen.opcode = opcode;
				seen.set_bits = set_bits;
				seen.used_bits = used_bits;
				seen.member_count = member_count;
				seen.index_in = index_in;
				seen.drain = 1'b0;
				expected_results.push_back(colex_result(seen));
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result beat", 1, 0);
				end else begin
					want = expected_results.pop_front();
					if (index_out !== want.index_out)
						report_mismatch("index_out", 32'(index_out), 32'(want.index_out));
					if (set_out !== want.set_out)
						report_mismatch("set_out", 32'(set_out), 32'(want.set_out));
					if (count_out !== want.count_out)
						report_mismatch("count_out", 32'(count_out), 32'(want.count_out));
					if (invalid !== want.invalid)
						report_mismatch("invalid", 32'(invalid), 32'(want.invalid));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		queue_directed();
		queue_random();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_operands.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
rtl/mcr_pkg.sv
rtl/mcr_ctrl.sv
rtl/mcr_datapath.sv
rtl/masked_combination_ranker.sv
tb/sv/tb_masked_combination_ranker.sv
